/* hw/rtl/top_k_peak_selector_defines.svh */
// assertion macros for the top-k peak selector
`ifndef TOP_K_PEAK_SELECTOR_DEFINES_SVH
`define TOP_K_PEAK_SELECTOR_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define TKPS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define TKPS_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

/* hw/rtl/tkps_pkg.sv */
// shared types and constants for the top-k peak selector
`timescale 1ns / 1ps

package tkps_pkg;

  localparam int DEF_MAX_PEAKS = 16;
  localparam int DEF_FRAME_MAX = 4096;

  localparam int VAL_W = 32;
  localparam int IDX_W = 12;
  localparam int POS_W = 32;
  localparam int RANK_W = 5;
  localparam int PCNT_W = 5;
  localparam int XOFF_W = 21;
  localparam int CFG_W = 21;
  localparam int CFG_ADDR_W = 1;

  localparam logic [CFG_ADDR_W-1:0] REG_PEAK_COUNT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_X_OFFSET = 1'd1;

  localparam logic [PCNT_W-1:0] PEAK_COUNT_RST = 5'd10;
  localparam logic [XOFF_W-1:0] X_OFFSET_RST = 21'h1f09e8; // -63000

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        index;
    logic signed [POS_W-1:0] pos;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic drain;
  } ctrl_t;

endpackage

/* hw/rtl/tkps_cell.sv */
// one slot of the sorted peak list: compare, hold, take new or shift
`timescale 1ns / 1ps

module tkps_cell (
  input  logic           clk,
  input  tkps_pkg::ctrl_t ctrl,
  input  tkps_pkg::entry_t new_entry,
  input  tkps_pkg::entry_t prev_entry,
  input  tkps_pkg::entry_t next_entry,
  input  logic           occ,
  input  logic           ge_prev,
  output logic           ge,
  output tkps_pkg::entry_t entry
);
  import tkps_pkg::*;

  entry_t entry_next;

  // occupied slot whose value stays ahead of the new sample (earlier wins ties)
  assign ge = occ && (entry.value >= new_entry.value);

  always_comb begin
    entry_next = entry;
    if (ctrl.insert) begin
      if (!ge) begin
        entry_next = ge_prev ? new_entry : prev_entry;
      end
    end else if (ctrl.drain) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

/* hw/rtl/top_k_peak_selector.sv */
// top level of the top-k peak selector: config, chain of slots, drain and output word
`timescale 1ns / 1ps
//
// Input stream: one sample word per beat, s_axis_tdata = {y_sample, x_raw},
// s_axis_tlast marks the final sample of a frame. Samples are taken at one
// word per cycle while s_axis_tready is high; each enters a chain of
// MAX_PEAKS compare-and-shift slots that keeps the largest amplitudes in
// descending order, ties keeping the earlier sample first.
// On the tlast word the list holds its final order in the next cycle. The
// block then reads out min(peak_count, MAX_PEAKS, filled) words by shifting
// the chain toward slot 0, one per cycle while the receiver takes them; the
// first result is registered once the state has turned to readout, and the
// last result carries m_axis_tlast. s_axis_tready is low during this
// readout; a zero count emits nothing.
// The output word sits in a register, so a receiver stall holds it and
// pauses the readout without losing data.
// Config writes (cfg_we, cfg_addr, cfg_data) take effect at the next edge.
// The user must make them while the block is idle; the block does not enforce
// it. Reset (rst, synchronous) restores peak_count 10 and x_offset -63000 and
// empties the list and the counter.
`include "top_k_peak_selector_defines.svh"

module top_k_peak_selector #(
  parameter int MAX_PEAKS = tkps_pkg::DEF_MAX_PEAKS,
  parameter int FRAME_MAX = tkps_pkg::DEF_FRAME_MAX
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tkps_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tkps_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [63:0]                     s_axis_tdata,  // x_raw[31:0], y_sample[63:32]
  input  logic                            s_axis_tlast,  // frame_end
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // rank[4:0], sample_index[16:5], x_corrected[48:17], y_peak[80:49], zeros[87:81]
  output logic [87:0]                     m_axis_tdata,
  output logic                            m_axis_tlast   // last_peak
);
  import tkps_pkg::*;

  localparam int CW = $clog2(MAX_PEAKS + 1);
  localparam int KW = (CW > PCNT_W) ? CW : PCNT_W;
  localparam int CNTW = $clog2(FRAME_MAX);

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t state;
  logic [PCNT_W-1:0] peak_count;
  logic [XOFF_W-1:0] x_offset;
  logic [CW-1:0] filled;
  logic [CW-1:0] filled_next;
  logic [CNTW-1:0] sample_counter;
  logic [CW-1:0] remain;
  logic [RANK_W-1:0] rank_cnt;

  logic in_acc;
  logic load;
  ctrl_t ctrl;
  entry_t new_entry;
  logic signed [POS_W:0] x_sum;
  logic signed [POS_W-1:0] x_sat;
  logic [KW-1:0] k_val;
  logic [KW-1:0] pc_ext;
  logic [KW-1:0] fill_ext;

  entry_t cell_q [MAX_PEAKS];
  logic [MAX_PEAKS-1:0] ge;
  logic [MAX_PEAKS-1:0] occ;

  logic [RANK_W-1:0] o_rank;
  logic [IDX_W-1:0] o_index;
  logic signed [POS_W-1:0] o_pos;
  logic signed [VAL_W-1:0] o_value;

  assign s_axis_tready = (state == ST_RUN);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign load = (state == ST_DRAIN) && (!m_axis_tvalid || m_axis_tready);
  assign ctrl = '{insert: in_acc, drain: load};

  // x plus offset with 33-bit sum, clamped to the 32-bit range
  assign x_sum = {s_axis_tdata[31], s_axis_tdata[31:0]}
               + {{(POS_W + 1 - XOFF_W){x_offset[XOFF_W-1]}}, x_offset};
  always_comb begin
    x_sat = x_sum[POS_W-1:0];
    if (x_sum[POS_W] != x_sum[POS_W-1]) begin
      x_sat = x_sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  assign new_entry = '{value: s_axis_tdata[63:32], index: IDX_W'(sample_counter), pos: x_sat};

  genvar gi;
  generate
    for (gi = 0; gi < MAX_PEAKS; gi++) begin : g_cell
      entry_t prev_e;
      entry_t next_e;
      logic   ge_p;
      assign occ[gi] = (filled > CW'(gi));
      if (gi == 0) begin : g_head
        assign prev_e = new_entry;
        assign ge_p = 1'b1;
      end else begin : g_body
        assign prev_e = cell_q[gi-1];
        assign ge_p = ge[gi-1];
      end
      if (gi == MAX_PEAKS - 1) begin : g_tail
        assign next_e = '0;
      end else begin : g_mid
        assign next_e = cell_q[gi+1];
      end
      tkps_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .new_entry  (new_entry),
        .prev_entry (prev_e),
        .next_entry (next_e),
        .occ        (occ[gi]),
        .ge_prev    (ge_p),
        .ge         (ge[gi]),
        .entry      (cell_q[gi])
      );
    end
  endgenerate

  // a full list keeps its size; otherwise every sample lands somewhere
  assign filled_next = (filled != CW'(MAX_PEAKS)) ? filled + 1'b1 : filled;

  // words to report: min(peak_count, MAX_PEAKS, filled after this sample)
  assign pc_ext = KW'(peak_count);
  assign fill_ext = KW'(filled_next);
  always_comb begin
    k_val = pc_ext;
    if (k_val > KW'(MAX_PEAKS)) begin
      k_val = KW'(MAX_PEAKS);
    end
    if (k_val > fill_ext) begin
      k_val = fill_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_count <= PEAK_COUNT_RST;
      x_offset <= X_OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PEAK_COUNT: peak_count <= cfg_data[PCNT_W-1:0];
        REG_X_OFFSET:   x_offset <= cfg_data[XOFF_W-1:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      filled <= '0;
      sample_counter <= '0;
      remain <= '0;
      rank_cnt <= '0;
    end else begin
      case (state)
        ST_RUN: begin
          if (in_acc) begin
            if (s_axis_tlast) begin
              filled <= '0;
              sample_counter <= '0;
              remain <= CW'(k_val);
              rank_cnt <= RANK_W'(1);
              if (k_val != '0) begin
                state <= ST_DRAIN;
              end
            end else begin
              filled <= filled_next;
              if (sample_counter != CNTW'(FRAME_MAX - 1)) begin
                sample_counter <= sample_counter + 1'b1;
              end
            end
          end
        end
        ST_DRAIN: begin
          if (load) begin
            remain <= remain - 1'b1;
            rank_cnt <= rank_cnt + 1'b1;
            if (remain == CW'(1)) begin
              state <= ST_RUN;
            end
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_rank <= rank_cnt;
      o_index <= cell_q[0].index;
      o_pos <= cell_q[0].pos;
      o_value <= cell_q[0].value;
      m_axis_tlast <= (remain == CW'(1));
    end
  end

  assign m_axis_tdata = {7'd0, o_value, o_pos, o_index, o_rank};

  `TKPS_ASSERT_ALWAYS(a_fill_bound, filled <= CW'(MAX_PEAKS), "peak list over capacity")
  `TKPS_ASSERT_NEXT(a_frame_clear, in_acc && s_axis_tlast, (filled == '0) && (sample_counter == '0), "frame end did not clear the list")
  `TKPS_ASSERT_ALWAYS(a_drain_count, (state != ST_DRAIN) || (remain != '0), "readout with nothing left")
  `TKPS_ASSERT_NEXT(a_last_done, load && (remain == CW'(1)), (state == ST_RUN) && m_axis_tlast, "last word did not end readout")

endmodule
